@@ hw/rtl/srpp_pkg.sv @@
package srpp_pkg;

    // fixed build constants of the pwm timebase
    localparam int unsigned CLOCK_HZ           = 125000000;
    localparam int unsigned PRESCALE           = 64;
    localparam int unsigned PHASE_CORRECT_MODE = 0;
    localparam int unsigned DEN_SCALE          = (1 + PHASE_CORRECT_MODE) * PRESCALE;
    localparam int unsigned US_PER_S           = 1000000;
    localparam int unsigned SEC_PER_MIN        = 60;

    // shared divider width and iteration counter width
    localparam int unsigned DIV_W   = 32;
    localparam int unsigned DIV_CNT = $clog2(DIV_W);

    typedef logic [DIV_W-1:0] t_div_word;

    // command codes
    localparam logic [1:0] CMD_RAMP   = 2'd0;
    localparam logic [1:0] CMD_ROTATE = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
    localparam logic [1:0] REG_MIN_SPEED     = 2'd1;
    localparam logic [1:0] REG_RAMP_RATE     = 2'd2;

    // clamp a quotient to the 16-bit pwm range
    function automatic logic [15:0] sat16(input t_div_word v);
        logic [15:0] r;
        r = (v > t_div_word'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/srpp_divider.sv @@
module srpp_divider
    import srpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_div_word i_dividend,
    input  t_div_word i_divisor,
    output logic      o_busy,
    output logic      o_done,
    output t_div_word o_quotient
);

    logic [DIV_W-1:0]   r_rem;
    t_div_word          r_q;
    t_div_word          r_dvs;
    logic [DIV_CNT-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    // one restoring step: shift in the next dividend bit, try a subtract
    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_sub;
    logic           w_ge;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ hw/rtl/stepper_ramp_pwm_planner.sv @@
// stop, unused codes, a reached target or a zero ramp rate go straight from accept to S_FINISH;
//   a ramp step that is not yet due runs one pacing division first; each division is a
//   32-step restoring loop, so a rotate that rescales both counters runs 4 divisions and a
//   paced ramp step that rescales both counters runs 5 divisions
// flow: one command in flight; the next beat is accepted in the cycle after the result is
//   registered, and an output stall holds it off; reset: synchronous, clears speed, wrap,
//   direction and step time; registers return to 200 steps, 1 rpm, 100 rpm/s
module stepper_ramp_pwm_planner
    import srpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic        i_direction,
    input  logic [11:0] i_target_rpm,
    input  logic [63:0] i_now_us,
    input  logic [15:0] i_count_a_now,
    input  logic [15:0] i_count_b_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drive_on,
    output logic [15:0] o_wrap_top,
    output logic [15:0] o_duty_level,
    output logic        o_write_counters,
    output logic [15:0] o_counter_a,
    output logic [15:0] o_counter_b,
    output logic [11:0] o_speed_rpm,
    output logic        o_ramp_done,
    output logic        o_changed
);

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT, S_ROT, S_FREQ, S_TOPD, S_CNT, S_CA, S_CB, S_COMMIT, S_FINISH
    } t_state;

    t_state r_state;

    // configuration
    logic [12:0] r_steps;
    logic [11:0] r_min;
    logic [19:0] r_ramp;

    // planner state
    logic [11:0] r_cur;
    logic [15:0] r_last_top;
    logic        r_last_dir;
    logic [63:0] r_last_step;

    // latched command
    logic [1:0]  r_cmd;
    logic        r_dir;
    logic [11:0] r_tgt;
    logic [63:0] r_now;
    logic [15:0] r_ca;
    logic [15:0] r_cb;
    logic [11:0] r_rpm;
    logic        r_stop_after;
    logic [15:0] r_top;

    // result under construction
    logic        r_res_drive;
    logic [15:0] r_res_top;
    logic [15:0] r_res_duty;
    logic        r_res_wr;
    logic [15:0] r_res_ca;
    logic [15:0] r_res_cb;
    logic [11:0] r_res_speed;
    logic        r_res_done;
    logic        r_res_changed;

    // output register
    logic        r_out_valid;
    logic        r_out_drive;
    logic [15:0] r_out_top;
    logic [15:0] r_out_duty;
    logic        r_out_wr;
    logic [15:0] r_out_ca;
    logic [15:0] r_out_cb;
    logic [11:0] r_out_speed;
    logic        r_out_done;
    logic        r_out_changed;

    // divider launch
    logic      r_div_go;
    t_div_word r_dvd;
    t_div_word r_dvs;
    logic      div_busy;
    logic      div_done;
    t_div_word div_q;

    srpp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // datapath helpers
    logic        w_accept;
    logic        w_is_stop;
    logic [63:0] w_diff;
    logic        w_late;
    logic [24:0] w_prod;
    logic [28:0] w_den;
    logic [15:0] w_top;
    logic [31:0] w_ca_prod;
    logic [31:0] w_cb_prod;
    logic [11:0] w_base;
    logic [11:0] w_next;
    logic [11:0] w_down;
    logic        w_out_free;

    assign w_accept   = i_valid && o_ready;
    assign w_is_stop  = (i_command == CMD_STOP);
    assign w_diff     = r_now - r_last_step;
    assign w_late     = (w_diff[63:20] != '0) || (w_diff[19:0] > div_q[19:0]);
    assign w_prod     = {13'b0, r_rpm} * {12'b0, r_steps};
    assign w_den      = {9'b0, div_q[19:0]} * 29'(DEN_SCALE);
    assign w_top      = (div_q == '0) ? 16'd0 : sat16(div_q - 1'b1);
    assign w_ca_prod  = {16'b0, r_ca} * {16'b0, r_top};
    assign w_cb_prod  = {16'b0, r_cb} * {16'b0, r_top};
    assign w_base     = (r_cur < r_min) ? r_min : r_cur;
    assign w_next     = (w_base == 12'hFFF) ? w_base : w_base + 1'b1;
    assign w_down     = r_cur - 1'b1;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= 13'd200;
            r_min       <= 12'd1;
            r_ramp      <= 20'd100;
            r_cur       <= '0;
            r_last_top  <= '0;
            r_last_dir  <= 1'b0;
            r_last_step <= '0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            // launch pulse lasts one cycle
            if (r_div_go) begin
                r_div_go <= 1'b0;
            end

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STEPS_PER_REV: r_steps <= i_cfg_data[12:0];
                    REG_MIN_SPEED:     r_min   <= i_cfg_data[11:0];
                    REG_RAMP_RATE:     r_ramp  <= i_cfg_data;
                    default:           ;
                endcase
            end

            // output beat taken
            if (r_out_valid && i_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd         <= i_command;
                        r_dir         <= i_direction;
                        r_tgt         <= i_target_rpm;
                        r_now         <= i_now_us;
                        r_ca          <= i_count_a_now;
                        r_cb          <= i_count_b_now;
                        r_rpm         <= i_target_rpm;
                        r_stop_after  <= 1'b0;
                        r_res_drive   <= !w_is_stop && (r_cur != '0);
                        r_res_top     <= w_is_stop ? 16'd0 : r_last_top;
                        r_res_duty    <= w_is_stop ? 16'd0 : (r_last_top >> 1);
                        r_res_wr      <= w_is_stop;
                        r_res_ca      <= '0;
                        r_res_cb      <= '0;
                        r_res_speed   <= w_is_stop ? 12'd0 : r_cur;
                        r_res_done    <= (i_command == CMD_RAMP) && (i_target_rpm == r_cur);
                        r_res_changed <= w_is_stop;
                        case (i_command)
                            CMD_ROTATE: r_state <= S_ROT;
                            CMD_STOP: begin
                                r_last_top <= '0;
                                r_cur      <= '0;
                                r_state    <= S_FINISH;
                            end
                            CMD_RAMP: begin
                                if (i_target_rpm != r_cur && r_ramp != '0) begin
                                    r_dvd    <= t_div_word'(US_PER_S);
                                    r_dvs    <= t_div_word'(r_ramp);
                                    r_div_go <= 1'b1;
                                    r_state  <= S_WAIT;
                                end else begin
                                    r_state <= S_FINISH;
                                end
                            end
                            default: r_state <= S_FINISH;
                        endcase
                    end
                end

                // ramp pacing against the step interval
                S_WAIT: begin
                    if (div_done) begin
                        if (w_late) begin
                            r_last_step <= r_now;
                            r_state     <= S_ROT;
                            if (r_tgt > r_cur) begin
                                r_rpm        <= w_next;
                                r_stop_after <= 1'b0;
                            end else begin
                                r_rpm        <= w_down;
                                r_stop_after <= (w_down < r_min);
                            end
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end

                // step frequency: rpm * steps / 60
                S_ROT: begin
                    if (r_rpm == '0) begin
                        r_res_drive   <= 1'b0;
                        r_res_top     <= '0;
                        r_res_duty    <= '0;
                        r_res_wr      <= 1'b1;
                        r_res_ca      <= '0;
                        r_res_cb      <= '0;
                        r_res_speed   <= '0;
                        r_res_changed <= 1'b1;
                        r_last_top    <= '0;
                        r_cur         <= '0;
                        r_state       <= S_FINISH;
                    end else begin
                        r_dvd    <= t_div_word'(w_prod);
                        r_dvs    <= t_div_word'(SEC_PER_MIN);
                        r_div_go <= 1'b1;
                        r_state  <= S_FREQ;
                    end
                end

                // wrap from clock over scaled frequency, or full scale when the frequency is zero
                S_FREQ: begin
                    if (div_done) begin
                        if (div_q == '0) begin
                            r_top   <= 16'hFFFF;
                            r_state <= S_CNT;
                        end else begin
                            r_dvd    <= t_div_word'(CLOCK_HZ);
                            r_dvs    <= t_div_word'(w_den);
                            r_div_go <= 1'b1;
                            r_state  <= S_TOPD;
                        end
                    end
                end

                S_TOPD: begin
                    if (div_done) begin
                        r_top   <= w_top;
                        r_state <= S_CNT;
                    end
                end

                // quadrature load or rescale of the live counters
                S_CNT: begin
                    r_res_drive <= 1'b1;
                    r_res_top   <= r_top;
                    r_res_duty  <= r_top >> 1;
                    r_res_wr    <= 1'b1;
                    if (r_last_top == '0 || r_last_dir != r_dir) begin
                        r_res_ca <= r_dir ? 16'd0 : (r_top >> 2);
                        r_res_cb <= r_dir ? (r_top >> 2) : 16'd0;
                        r_state  <= S_COMMIT;
                    end else begin
                        r_dvd    <= w_ca_prod;
                        r_dvs    <= t_div_word'(r_last_top);
                        r_div_go <= 1'b1;
                        r_state  <= S_CA;
                    end
                end

                S_CA: begin
                    if (div_done) begin
                        r_res_ca <= sat16(div_q);
                        r_dvd    <= w_cb_prod;
                        r_dvs    <= t_div_word'(r_last_top);
                        r_div_go <= 1'b1;
                        r_state  <= S_CB;
                    end
                end

                S_CB: begin
                    if (div_done) begin
                        r_res_cb <= sat16(div_q);
                        r_state  <= S_COMMIT;
                    end
                end

                // new settings take effect; deceleration below minimum stops
                S_COMMIT: begin
                    r_last_dir    <= r_dir;
                    r_res_changed <= 1'b1;
                    if (r_stop_after) begin
                        r_res_drive <= 1'b0;
                        r_res_top   <= '0;
                        r_res_duty  <= '0;
                        r_res_ca    <= '0;
                        r_res_cb    <= '0;
                        r_res_speed <= '0;
                        r_last_top  <= '0;
                        r_cur       <= '0;
                    end else begin
                        r_res_speed <= r_rpm;
                        r_last_top  <= r_top;
                        r_cur       <= r_rpm;
                    end
                    r_state <= S_FINISH;
                end

                // hand the result to the output register
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_drive   <= r_res_drive;
                        r_out_top     <= r_res_top;
                        r_out_duty    <= r_res_duty;
                        r_out_wr      <= r_res_wr;
                        r_out_ca      <= r_res_ca;
                        r_out_cb      <= r_res_cb;
                        r_out_speed   <= r_res_speed;
                        r_out_done    <= r_res_done;
                        r_out_changed <= r_res_changed;
                        r_state       <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_drive_on       = r_out_drive;
    assign o_wrap_top       = r_out_top;
    assign o_duty_level     = r_out_duty;
    assign o_write_counters = r_out_wr;
    assign o_counter_a      = r_out_ca;
    assign o_counter_b      = r_out_cb;
    assign o_speed_rpm      = r_out_speed;
    assign o_ramp_done      = r_out_done;
    assign o_changed        = r_out_changed;

`ifndef SYNTHESIS
    a_div_idle_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !div_busy)
        else $error("divider launched while busy");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("second beat accepted while a command is in flight");

    a_stopped_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) |-> (r_last_top == '0))
        else $error("wrap value kept with motor stopped");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import srpp_pkg::*;

    // plan beat as seen on the result side
    typedef struct packed {
        logic        drive_on;
        logic [15:0] wrap_top;
        logic [15:0] duty_level;
        logic        write_counters;
        logic [15:0] counter_a;
        logic [15:0] counter_b;
        logic [11:0] speed_rpm;
        logic        ramp_done;
        logic        changed;
    } t_plan;

    // one command beat
    typedef struct packed {
        logic [1:0]  command;
        logic        direction;
        logic [11:0] target_rpm;
        logic [63:0] now_us;
        logic [15:0] count_a_now;
        logic [15:0] count_b_now;
    } t_cmd;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS   = 1630;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_STEPS_PER_REV;
    logic [19:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_STOP;
    logic        i_direction = 1'b0;
    logic [11:0] i_target_rpm = '0;
    logic [63:0] i_now_us = '0;
    logic [15:0] i_count_a_now = '0;
    logic [15:0] i_count_b_now = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_drive_on;
    logic [15:0] o_wrap_top;
    logic [15:0] o_duty_level;
    logic        o_write_counters;
    logic [15:0] o_counter_a;
    logic [15:0] o_counter_b;
    logic [11:0] o_speed_rpm;
    logic        o_ramp_done;
    logic        o_changed;

    stepper_ramp_pwm_planner dut (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [12:0] pl_steps;
    logic [11:0] pl_min_rpm;
    logic [19:0] pl_rate;
    logic [11:0] pl_rpm;
    logic [15:0] pl_top;
    logic        pl_dir;
    logic [63:0] pl_step_time;

    t_plan plan_queue[$];
    int    error_count = 0;
    bit    quiet_mode = 0;
    bit    long_hold = 0;
    bit    stim_done = 0;
    int    idle_cycles = 0;
    logic [63:0] time_us = 0;

    function automatic void plan_reset();
        pl_steps = 13'd200;
        pl_min_rpm = 12'd1;
        pl_rate = 20'd100;
        pl_rpm = '0;
        pl_top = '0;
        pl_dir = 1'b0;
        pl_step_time = '0;
    endfunction

    function automatic void plan_stop(ref t_plan p);
        p.drive_on = 1'b0;
        p.wrap_top = '0;
        p.duty_level = '0;
        p.write_counters = 1'b1;
        p.counter_a = '0;
        p.counter_b = '0;
        pl_top = '0;
        pl_rpm = '0;
    endfunction

    function automatic logic [15:0] clamp16(logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void plan_rotate(ref t_plan p, input logic dir, input logic [11:0] rpm,
                                        input logic [15:0] ca, input logic [15:0] cb);
        logic [63:0] freq;
        logic [63:0] den;
        logic [63:0] quo;
        logic [15:0] top;
        if (rpm == 0) begin
            plan_stop(p);
            return;
        end
        freq = (64'(rpm) * 64'(pl_steps)) / 64'd60;
        den = 64'(DEN_SCALE) * freq;
        if (den == 0) begin
            top = 16'hFFFF;
        end else begin
            quo = 64'(CLOCK_HZ) / den;
            top = (quo == 0) ? 16'd0 : clamp16(quo - 1);
        end
        p.drive_on = 1'b1;
        p.wrap_top = top;
        p.duty_level = top / 16'd2;
        p.write_counters = 1'b1;
        if (pl_top == 0 || pl_dir != dir) begin
            p.counter_a = dir ? 16'd0 : top / 16'd4;
            p.counter_b = dir ? top / 16'd4 : 16'd0;
        end else begin
            p.counter_a = clamp16((64'(ca) * 64'(top)) / 64'(pl_top));
            p.counter_b = clamp16((64'(cb) * 64'(top)) / 64'(pl_top));
        end
        pl_top = top;
        pl_dir = dir;
        pl_rpm = rpm;
    endfunction

    function automatic t_plan plan_command(t_cmd c);
        t_plan p;
        logic [63:0] wait_us;
        logic [11:0] next_rpm;
        p = '0;
        p.drive_on = (pl_rpm != 0);
        p.wrap_top = pl_top;
        p.duty_level = pl_top / 16'd2;
        if (c.command == CMD_ROTATE) begin
            plan_rotate(p, c.direction, c.target_rpm, c.count_a_now, c.count_b_now);
            p.changed = 1'b1;
        end else if (c.command == CMD_STOP) begin
            plan_stop(p);
            p.changed = 1'b1;
        end else if (c.command == CMD_RAMP) begin
            if (c.target_rpm == pl_rpm) begin
                p.ramp_done = 1'b1;
            end else begin
                wait_us = (pl_rate == 0) ? '1 : 64'(US_PER_S) / 64'(pl_rate);
                if (c.now_us - pl_step_time > wait_us) begin
                    if (c.target_rpm > pl_rpm) begin
                        if (pl_rpm < pl_min_rpm) pl_rpm = pl_min_rpm;
                        next_rpm = (pl_rpm == 12'hFFF) ? 12'hFFF : pl_rpm + 12'd1;
                        plan_rotate(p, c.direction, next_rpm, c.count_a_now, c.count_b_now);
                    end else begin
                        plan_rotate(p, c.direction, pl_rpm - 12'd1, c.count_a_now,
                                    c.count_b_now);
                        if (pl_rpm < pl_min_rpm) plan_stop(p);
                    end
                    pl_step_time = c.now_us;
                    p.changed = 1'b1;
                end
            end
        end
        p.speed_rpm = pl_rpm;
        return p;
    endfunction

    // sender: one beat, then sometimes a random gap
    task automatic send_cmd(input t_cmd c, input bit has_fixed, input t_plan fixed);
        t_plan p;
        i_valid <= 1'b1;
        {i_command, i_direction, i_target_rpm, i_now_us, i_count_a_now, i_count_b_now} <= c;
        do @(posedge i_clk); while (!o_ready);
        p = plan_command(c);
        if (has_fixed && p != fixed) begin
            $display("%0t: directed row mismatch expected %h actual plan %h", $time, fixed, p);
            error_count++;
        end
        plan_queue.push_back(p);
        @(negedge i_clk);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic idle_block();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (plan_queue.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_STEPS_PER_REV: pl_steps = val[12:0];
            REG_MIN_SPEED: pl_min_rpm = val[11:0];
            default: pl_rate = val;
        endcase
    endtask

    function automatic t_cmd rand_cmd(int mode);
        t_cmd c;
        c.direction = ($urandom_range(0, 9) == 0) ? ~pl_dir : 1'($urandom_range(0, 1));
        c.count_a_now = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        c.count_b_now = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        time_us += $urandom_range(0, 4) == 0 ? 64'($urandom_range(0, 50))
                                              : 64'($urandom_range(1000, 30000));
        c.now_us = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : time_us;
        c.target_rpm = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
        case ($urandom_range(0, 19))
            0, 1, 2: c.command = CMD_ROTATE;
            3: c.command = CMD_STOP;
            4: c.command = 2'd3;
            default: c.command = CMD_RAMP;
        endcase
        if (mode == 1 && c.command == CMD_RAMP)
            c.target_rpm = pl_rpm + 12'($urandom_range(0, 2)) - 12'd1;
        return c;
    endfunction

    // directed rows
    typedef struct {
        t_cmd  c;
        bit    has_fixed;
        t_plan fixed;
    } t_row;

    t_row dir_rows[$];

    function automatic t_plan plan_of(logic d, logic [15:0] t, logic w, logic [15:0] a,
                                      logic [15:0] b, logic [11:0] s, logic r, logic ch);
        t_plan p;
        p = {d, t, t / 16'd2, w, a, b, s, r, ch};
        return p;
    endfunction

    initial begin
        t_cmd c;
        t_plan none;
        none = '0;
        plan_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: fixed results where obvious
        dir_rows.push_back('{'{CMD_RAMP, 1'b0, 12'd0, 64'd5, 16'd0, 16'd0}, 1,
                             plan_of(0, 0, 0, 0, 0, 0, 1, 0)});
        dir_rows.push_back('{'{2'd3, 1'b1, 12'hFFF, '1, '1, '1}, 1,
                             plan_of(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{'{CMD_STOP, 1'b1, 12'hFFF, '1, '1, '1}, 1,
                             plan_of(0, 0, 1, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{'{CMD_ROTATE, 1'b0, 12'd0, 64'd0, 16'd9, 16'd9}, 1,
                             plan_of(0, 0, 1, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{'{CMD_ROTATE, 1'b0, 12'd60, 64'd0, 16'd0, 16'd0}, 0, none});
        dir_rows.push_back('{'{CMD_ROTATE, 1'b0, 12'd61, 64'd0, '1, '1}, 0, none});
        dir_rows.push_back('{'{CMD_ROTATE, 1'b1, 12'hFFF, 64'd0, 16'h1234, '1}, 0, none});
        dir_rows.push_back('{'{CMD_ROTATE, 1'b1, 12'd1, 64'd0, '1, '1}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b1, 12'd5, 64'd20000, 16'd7, 16'd7}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b1, 12'd5, 64'd20001, 16'd7, 16'd7}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b1, 12'd0, 64'd30002, 16'd7, 16'd7}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b0, 12'd0, 64'd10, 16'd7, 16'd7}, 0, none});
        dir_rows.push_back('{'{CMD_STOP, 1'b0, 12'd0, 64'd0, 16'd0, 16'd0}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b0, 12'd9, '1, 16'd0, 16'd0}, 0, none});
        dir_rows.push_back('{'{CMD_RAMP, 1'b0, 12'd0, '1, 16'd0, 16'd0}, 0, none});
        foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].has_fixed, dir_rows[i].fixed);

        // register extremes: zero step frequency, saturated ramp start, fastest rate
        idle_block();
        write_reg(REG_STEPS_PER_REV, 20'd1);
        write_reg(REG_MIN_SPEED, 20'd4095);
        write_reg(REG_RAMP_RATE, 20'd1000000);
        send_cmd('{CMD_ROTATE, 1'b0, 12'd1, 64'd0, 16'd0, 16'd0}, 0, none);
        send_cmd('{CMD_RAMP, 1'b0, 12'hFFF, 64'd100, 16'd0, 16'd0}, 0, none);
        send_cmd('{CMD_RAMP, 1'b0, 12'd0, 64'd200, 16'd0, 16'd0}, 0, none);
        idle_block();
        write_reg(REG_STEPS_PER_REV, 20'd4096);
        write_reg(REG_MIN_SPEED, 20'd0);
        write_reg(REG_RAMP_RATE, 20'd0);
        send_cmd('{CMD_ROTATE, 1'b1, 12'hFFF, 64'd0, 16'd0, 16'd0}, 0, none);
        send_cmd('{CMD_RAMP, 1'b1, 12'd0, '1, 16'd0, 16'd0}, 0, none);

        // random phases under several register settings
        for (int ph = 0; ph < 5; ph++) begin
            idle_block();
            write_reg(REG_STEPS_PER_REV, 20'($urandom_range(1, 4096)));
            write_reg(REG_MIN_SPEED, ph == 4 ? 20'd4094 : 20'($urandom_range(0, 20)));
            write_reg(REG_RAMP_RATE, ph == 0 ? 20'd1 : 20'($urandom_range(1, 1000)));
            if (ph == 2) long_hold = 1;
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if (ph == 4 && n > RANDOM_ITEMS / 10) quiet_mode = 1;
                c = rand_cmd(n % 3 == 0);
                send_cmd(c, 0, none);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (long_hold) begin
            i_ready <= 1'b0;
            long_hold = 0;
            repeat (600) @(negedge i_clk);
            i_ready <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result check against oldest expectation
    always @(posedge i_clk) begin
        t_plan got;
        t_plan exp_plan;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_drive_on, o_wrap_top, o_duty_level, o_write_counters, o_counter_a,
                   o_counter_b, o_speed_rpm, o_ramp_done, o_changed};
            if (plan_queue.size() == 0) begin
                $display("%0t: unexpected plan beat actual %h", $time, got);
                error_count++;
            end else begin
                exp_plan = plan_queue.pop_front();
                if (got != exp_plan) begin
                    $display("%0t: plan mismatch expected %h actual %h", $time, exp_plan, got);
                    if (got.wrap_top != exp_plan.wrap_top)
                        $display("%0t: wrap_top expected %0d actual %0d", $time,
                                 exp_plan.wrap_top, got.wrap_top);
                    if (got.counter_a != exp_plan.counter_a || got.counter_b != exp_plan.counter_b)
                        $display("%0t: counters expected %0d/%0d actual %0d/%0d", $time,
                                 exp_plan.counter_a, exp_plan.counter_b,
                                 got.counter_a, got.counter_b);
                    if (got.speed_rpm != exp_plan.speed_rpm)
                        $display("%0t: speed expected %0d actual %0d", $time,
                                 exp_plan.speed_rpm, got.speed_rpm);
                    error_count++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (stim_done && plan_queue.size() == 0 && idle_cycles >= 300) begin
            if (error_count == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("Testbench completed WITH ERRORS");
            end
            $finish;
        end
    end

endmodule

@@ filelist.f @@
hw/rtl/srpp_pkg.sv
hw/rtl/srpp_divider.sv
hw/rtl/stepper_ramp_pwm_planner.sv
tb/tb_top.sv
